// ----- rtl/core/oht_pkg.sv -----
// Shared types for the Otsu histogram threshold unit.
// Command and status bundles between controller and datapath; no dependencies.
`default_nettype none
package oht_pkg;

  localparam int BIN_W     = 8;
  localparam int BIN_COUNT = 256;

  // Product that the shared multiplier works on for one bin.
  typedef enum logic [2:0] {
    OP_A   = 3'd0,  // wF * sumB
    OP_B   = 3'd1,  // wB * sumF
    OP_DEN = 3'd2,  // wB * wF
    OP_NUM = 3'd3,  // d * d
    OP_LHS = 3'd4,  // num * best_den
    OP_RHS = 3'd5   // best_num * den
  } op_t;

  typedef struct packed {
    logic pix_acc;    // pixel request taken this cycle
    logic scan_init;  // reset scan accumulators
    logic scan_rd;    // read bin at scan index
    logic scan_acc;   // fold bin count into wB / sumB
    logic adv;        // next bin
    logic mul_go;     // start multiply for op
    logic mul_take;   // store product for op
    op_t  op;
    logic cmp;        // compare candidate with best
    logic clr;        // drop histogram and totals
  } cmd_t;

  typedef struct packed {
    logic wb_zero;
    logic wf_zero;
    logic last_bin;
    logic mul_idle;
  } sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/oht_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module oht_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] wa,
  input  wire logic [W-1:0]         wd,
  input  wire logic                 re,
  input  wire logic [$clog2(D)-1:0] ra,
  output logic      [W-1:0]         rd
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/oht_mul.sv -----
// Shift-add multiplier, one multiplier bit per cycle, stops early when the
// remaining multiplier bits are zero. No dependencies.
`default_nettype none
module oht_mul #(
  parameter int XW = 8,
  parameter int YW = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               go,
  input  wire logic [XW-1:0]      x,
  input  wire logic [YW-1:0]      y,
  output logic                    busy,
  output logic      [XW+YW-1:0]   prod
);

  localparam int PW = XW + YW;

  logic [PW-1:0] x_r, x_nxt, acc_r, acc_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic          busy_r, busy_nxt;

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    acc_nxt  = acc_r;
    busy_nxt = busy_r;
    if (go) begin
      x_nxt    = {{YW{1'b0}}, x};
      y_nxt    = y;
      acc_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (y_r == '0) begin
        busy_nxt = 1'b0;
      end else begin
        if (y_r[0]) begin
          acc_nxt = acc_r + x_r;
        end
        x_nxt = x_r << 1;
        y_nxt = y_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    acc_r <= acc_nxt;
  end

  assign busy = busy_r;
  assign prod = acc_r;

endmodule
`default_nettype wire

// ----- rtl/core/oht_dp.sv -----
// Datapath: histogram RAM with forwarding, totals, scan accumulators and the
// exact variance compare. Uses oht_pkg, oht_ram, oht_mul.
`default_nettype none
module oht_dp
  import oht_pkg::*;
#(
  parameter int MAX_PIXELS_LOG2 = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  input  wire logic [BIN_W-1:0] pixel,
  output sts_t                  sts,
  output logic      [BIN_W-1:0] best
);

  localparam int CW = MAX_PIXELS_LOG2 + 1;  // pixel and bin counts
  localparam int SW = CW + BIN_W;           // intensity sums
  localparam int DW = CW + SW;              // a, b, d
  localparam int EW = 2 * CW;               // den
  localparam int NW = 2 * DW;               // num
  localparam int PW = NW + DW;              // lhs, rhs

  // frame totals and histogram valid bits
  logic [CW-1:0]        tot_r, tot_nxt;
  logic [SW-1:0]        isum_r, isum_nxt;
  logic [BIN_COUNT-1:0] vld_r, vld_nxt;

  // pixel update pipe
  logic             s1_vld_r;
  logic [BIN_W-1:0] s1_pix_r;
  logic             rvb_r;
  logic             w_vld_r;
  logic [BIN_W-1:0] w_addr_r;
  logic [CW-1:0]    w_data_r;

  logic             pix_take;
  logic [CW-1:0]    old_cnt;
  logic             ram_we, ram_re;
  logic [BIN_W-1:0] ram_wa, ram_ra;
  logic [CW-1:0]    ram_wd, ram_rd;

  // scan
  logic [BIN_W-1:0] idx_r, idx_nxt, best_r, best_nxt;
  logic [CW-1:0]    wb_r, wb_nxt;
  logic [SW-1:0]    sumb_r, sumb_nxt;
  logic [NW-1:0]    bnum_r, bnum_nxt, num_r, num_nxt;
  logic [EW-1:0]    bden_r, bden_nxt, den_r, den_nxt;
  logic [DW-1:0]    a_r, a_nxt, b_r, b_nxt;
  logic [PW-1:0]    lhs_r, lhs_nxt, rhs_r, rhs_nxt;

  logic [CW-1:0]    scan_cnt, wf;
  logic [SW-1:0]    sumf;
  logic [DW-1:0]    d;
  logic [NW-1:0]    mx;
  logic [DW-1:0]    my;
  logic             mul_busy;
  logic [PW-1:0]    prod;

  assign pix_take = cmd.pix_acc & ~tot_r[CW-1];

  // same-bin back-to-back: RAM read raced the write, take the written value
  assign old_cnt = (w_vld_r && (w_addr_r == s1_pix_r)) ? w_data_r :
                   (rvb_r ? ram_rd : '0);

  assign ram_we = s1_vld_r;
  assign ram_wa = s1_pix_r;
  assign ram_wd = old_cnt + CW'(1);
  assign ram_re = pix_take | cmd.scan_rd;
  assign ram_ra = cmd.scan_rd ? idx_r : pixel;

  oht_ram #(.W(CW), .D(BIN_COUNT)) u_hist (
    .clk (clk),
    .we  (ram_we),
    .wa  (ram_wa),
    .wd  (ram_wd),
    .re  (ram_re),
    .ra  (ram_ra),
    .rd  (ram_rd)
  );

  assign scan_cnt = rvb_r ? ram_rd : '0;
  assign wf       = tot_r - wb_r;
  assign sumf     = isum_r - sumb_r;
  assign d        = (a_r > b_r) ? (a_r - b_r) : (b_r - a_r);

  always_comb begin
    unique case (cmd.op)
      OP_A:    begin mx = NW'(sumb_r); my = DW'(wf);     end
      OP_B:    begin mx = NW'(sumf);   my = DW'(wb_r);   end
      OP_DEN:  begin mx = NW'(wb_r);   my = DW'(wf);     end
      OP_NUM:  begin mx = NW'(d);      my = d;           end
      OP_LHS:  begin mx = num_r;       my = DW'(bden_r); end
      OP_RHS:  begin mx = bnum_r;      my = DW'(den_r);  end
      default: begin mx = '0;          my = '0;          end
    endcase
  end

  oht_mul #(.XW(NW), .YW(DW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .x     (mx),
    .y     (my),
    .busy  (mul_busy),
    .prod  (prod)
  );

  always_comb begin
    tot_nxt  = tot_r;
    isum_nxt = isum_r;
    vld_nxt  = vld_r;
    if (pix_take) begin
      tot_nxt  = tot_r + CW'(1);
      isum_nxt = isum_r + SW'(pixel);
    end
    if (s1_vld_r) begin
      vld_nxt[s1_pix_r] = 1'b1;
    end
    if (cmd.clr) begin
      tot_nxt  = '0;
      isum_nxt = '0;
      vld_nxt  = '0;
    end
  end

  always_comb begin
    idx_nxt  = idx_r;
    best_nxt = best_r;
    wb_nxt   = wb_r;
    sumb_nxt = sumb_r;
    bnum_nxt = bnum_r;
    bden_nxt = bden_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    den_nxt  = den_r;
    num_nxt  = num_r;
    lhs_nxt  = lhs_r;
    rhs_nxt  = rhs_r;
    if (cmd.scan_init) begin
      idx_nxt  = '0;
      best_nxt = '0;
      wb_nxt   = '0;
      sumb_nxt = '0;
      bnum_nxt = '0;
      bden_nxt = EW'(1);
    end
    if (cmd.scan_acc) begin
      wb_nxt   = wb_r + scan_cnt;
      sumb_nxt = sumb_r + SW'(idx_r) * SW'(scan_cnt);
    end
    if (cmd.adv) begin
      idx_nxt = idx_r + BIN_W'(1);
    end
    if (cmd.mul_take) begin
      unique case (cmd.op)
        OP_A:    a_nxt   = prod[DW-1:0];
        OP_B:    b_nxt   = prod[DW-1:0];
        OP_DEN:  den_nxt = prod[EW-1:0];
        OP_NUM:  num_nxt = prod[NW-1:0];
        OP_LHS:  lhs_nxt = prod;
        OP_RHS:  rhs_nxt = prod;
        default: ;
      endcase
    end
    if (cmd.cmp && (lhs_r > rhs_r)) begin
      bnum_nxt = num_r;
      bden_nxt = den_r;
      best_nxt = idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r    <= '0;
      isum_r   <= '0;
      vld_r    <= '0;
      s1_vld_r <= 1'b0;
      w_vld_r  <= 1'b0;
    end else begin
      tot_r    <= tot_nxt;
      isum_r   <= isum_nxt;
      vld_r    <= vld_nxt;
      s1_vld_r <= pix_take;
      w_vld_r  <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_pix_r <= pixel;
    if (ram_re) begin
      rvb_r <= vld_r[ram_ra];
    end
    w_addr_r <= s1_pix_r;
    w_data_r <= ram_wd;
    idx_r    <= idx_nxt;
    best_r   <= best_nxt;
    wb_r     <= wb_nxt;
    sumb_r   <= sumb_nxt;
    bnum_r   <= bnum_nxt;
    bden_r   <= bden_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    den_r    <= den_nxt;
    num_r    <= num_nxt;
    lhs_r    <= lhs_nxt;
    rhs_r    <= rhs_nxt;
  end

  assign sts.wb_zero  = (wb_r == '0);
  assign sts.wf_zero  = (wf == '0);
  assign sts.last_bin = &idx_r;
  assign sts.mul_idle = ~mul_busy;
  assign best         = best_r;

endmodule
`default_nettype wire

// ----- rtl/core/oht_ctrl.sv -----
// Controller: pixel intake, per-bin scan sequence, result handoff.
// Uses oht_pkg.
`default_nettype none
module oht_ctrl
  import oht_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_frame_last,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  wire sts_t sts,
  output cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DRAIN = 9'b000000010,
    S_RD    = 9'b000000100,
    S_ACC   = 9'b000001000,
    S_CHK   = 9'b000010000,
    S_GO    = 9'b000100000,
    S_WAIT  = 9'b001000000,
    S_CMP   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    cmd       = '0;
    cmd.op    = op_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.pix_acc = in_valid;
        if (in_valid && in_frame_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.scan_init = 1'b1;
        state_nxt     = S_RD;
      end
      S_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = S_ACC;
      end
      S_ACC: begin
        cmd.scan_acc = 1'b1;
        state_nxt    = S_CHK;
      end
      S_CHK: begin
        priority if (sts.wb_zero) begin
          if (sts.last_bin) begin
            state_nxt = S_OUT;
          end else begin
            cmd.adv   = 1'b1;
            state_nxt = S_RD;
          end
        end else if (sts.wf_zero) begin
          state_nxt = S_OUT;
        end else begin
          op_nxt    = OP_A;
          state_nxt = S_GO;
        end
      end
      S_GO: begin
        cmd.mul_go = 1'b1;
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        if (sts.mul_idle) begin
          cmd.mul_take = 1'b1;
          unique case (op_r)
            OP_A:    begin op_nxt = OP_B;   state_nxt = S_GO;  end
            OP_B:    begin op_nxt = OP_DEN; state_nxt = S_GO;  end
            OP_DEN:  begin op_nxt = OP_NUM; state_nxt = S_GO;  end
            OP_NUM:  begin op_nxt = OP_LHS; state_nxt = S_GO;  end
            OP_LHS:  begin op_nxt = OP_RHS; state_nxt = S_GO;  end
            default: state_nxt = S_CMP;
          endcase
        end
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.last_bin) begin
          state_nxt = S_OUT;
        end else begin
          cmd.adv   = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.clr   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      op_r    <= OP_A;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/otsu_histogram_threshold_unit.sv -----
// Top level of the Otsu histogram threshold unit.
// Uses oht_pkg, oht_ctrl, oht_dp (which holds oht_ram and oht_mul).
//
//   channel | ports                                   | dir | request moves
//   --------+-----------------------------------------+-----+---------------------
//   in      | in_valid in_ready in_pixel_value        | in  | one grey pixel
//           | in_frame_last                           |     |
//   out     | out_valid out_ready out_best_threshold  | out | one threshold/frame
//
// Cycles: a pixel request is taken every cycle while the unit is collecting.
//   The histogram RAM is read on acceptance and written in the cycle after; a
//   repeat of the same bin in the next cycle is forwarded from the write.
// After the last pixel: a drain state, then per bin a read, accumulate and
//   check step, which is all when the bin is skipped, or else six multiplies
//   and a compare; the bit-serial shift-add multiplier sets the scan length.
// Reset: synchronous active-low rst_n clears the histogram valid bits,
//   totals and the state machine; the RAM contents need no clearing pass.
// Stalls: in_ready is low from the last pixel until the result request is
//   taken; the histogram and totals are dropped at that handoff.
// Pixels past 2^MAX_PIXELS_LOG2 in one frame are ignored; a dropped last
//   pixel still closes the frame.
`default_nettype none
module otsu_histogram_threshold_unit
  import oht_pkg::*;
#(
  parameter int MAX_PIXELS_LOG2 = 20
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [BIN_W-1:0] in_pixel_value,
  input  wire logic             in_frame_last,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [BIN_W-1:0] out_best_threshold
);

  cmd_t cmd;
  sts_t sts;

  // controller sequences intake, the per-bin scan and the handoff
  oht_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_frame_last (in_frame_last),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  // histogram, totals and exact variance compare
  oht_dp #(.MAX_PIXELS_LOG2(MAX_PIXELS_LOG2)) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .pixel (in_pixel_value),
    .sts   (sts),
    .best  (out_best_threshold)
  );

  // collection and result handoff never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("intake open while a result is pending");

  // the last pixel closes intake
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_frame_last) |=> !in_ready)
    else $error("intake still open after the last pixel");

  // a taken result reopens intake
  a_out_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready) |=> (in_ready && !out_valid))
    else $error("intake not reopened after result handoff");

endmodule
`default_nettype wire

// ----- tb/tb_otsu_histogram_threshold_unit.sv -----
// Self-checking testbench for otsu_histogram_threshold_unit.
// Streams pixel frames, predicts the Otsu threshold per frame and checks each
// result request; uses oht_pkg and the RTL only.
module tb_otsu_histogram_threshold_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import oht_pkg::*;

  localparam int MAX_LOG2 = 20;
  localparam int CYCLE_LIMIT = 20000000;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [BIN_W-1:0] in_pixel_value;
  logic             in_frame_last;
  logic             out_valid;
  logic             out_ready;
  logic [BIN_W-1:0] out_best_threshold;

  otsu_histogram_threshold_unit #(.MAX_PIXELS_LOG2(MAX_LOG2)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pixel_value(in_pixel_value), .in_frame_last(in_frame_last),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_best_threshold(out_best_threshold)
  );

  // Predictor state: histogram and totals of the frame being collected.
  logic [20:0] hist [BIN_COUNT];
  logic [20:0] pix_count;
  logic [28:0] int_sum;
  logic [BIN_W-1:0] thresh_q[$];

  int mismatches;
  int cycles;
  int send_idle_pct;   // sender gap chance, percent
  int recv_idle_pct;   // receiver stall chance, percent
  bit hold_off;        // long receiver hold-off in progress

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Exact Otsu search: variance num/den compared by cross-multiplying.
  function automatic logic [BIN_W-1:0] otsu_threshold();
    logic [63:0]  wb, sumb, wf, sumf, a, b, d, den, best_den;
    logic [127:0] num, best_num;
    logic [191:0] lhs, rhs;
    logic [BIN_W-1:0] best;
    wb = 0; sumb = 0; best_num = 0; best_den = 1; best = 0;
    for (int i = 0; i < BIN_COUNT; i++) begin
      wb += hist[i];
      if (wb == 0) continue;
      wf = 64'(pix_count) - wb;
      if (wf == 0) break;
      sumb += 64'(i) * hist[i];
      sumf = 64'(int_sum) - sumb;
      a = wf * sumb;
      b = wb * sumf;
      d = (a > b) ? a - b : b - a;
      den = wb * wf;
      num = 128'(d) * 128'(d);
      lhs = 192'(num) * 192'(best_den);
      rhs = 192'(best_num) * 192'(den);
      if (lhs > rhs) begin
        best_num = num;
        best_den = den;
        best = BIN_W'(i);
      end
    end
    return best;
  endfunction

  // Fold one accepted pixel into the prediction; close frame on last.
  function automatic void predict_pixel(logic [BIN_W-1:0] p, logic last);
    if (pix_count < (21'd1 << MAX_LOG2)) begin
      hist[p] = hist[p] + 1;
      pix_count++;
      int_sum += p;
    end
    if (last) begin
      thresh_q = {thresh_q, otsu_threshold()};
      foreach (hist[i]) hist[i] = '0;
      pix_count = '0;
      int_sum = '0;
    end
  endfunction

  // Send one pixel request; valid held until accepted.
  task automatic send_pixel(logic [BIN_W-1:0] p, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_value <= p;
    in_frame_last <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pixel(p, last);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (thresh_q.size() != 0);
  endtask

  task automatic send_frame(int n, int lo, int hi);
    for (int i = 0; i < n; i++)
      send_pixel(BIN_W'($urandom_range(hi, lo)), i == n - 1);
  endtask

  // Receiver ready: random stalls, or held low during a hold-off.
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
  end

  // Result checker, sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (thresh_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d", out_best_threshold);
      end else begin
        if (out_best_threshold !== thresh_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("threshold mismatch: exp %0d got %0d", thresh_q[0], out_best_threshold);
        end
        void'(thresh_q.pop_front());
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Directed: extremes, single intensity, ties, one-pixel frame.
  task automatic test_directed();
    send_pixel(8'd0, 1'b1);                       // one pixel
    send_pixel(8'd255, 1'b0); send_pixel(8'd255, 1'b1);  // single intensity
    send_pixel(8'd0, 1'b0); send_pixel(8'd255, 1'b1);    // two extremes
    send_pixel(8'd10, 1'b0); send_pixel(8'd20, 1'b0);
    send_pixel(8'd30, 1'b1);                             // symmetric tie
    send_pixel(8'd0, 1'b0); send_pixel(8'd0, 1'b0); send_pixel(8'd128, 1'b0);
    send_pixel(8'd255, 1'b0); send_pixel(8'd255, 1'b1);
    for (int i = 0; i < 8; i++) send_pixel(BIN_W'(1 << i), i == 7);  // each bit
    send_pixel(8'd85, 1'b0); send_pixel(8'd170, 1'b1);
    wait_drained();
  endtask

  // Random frames of small size, occasional wider spreads.
  task automatic test_random(int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      n = $urandom_range(12, 1);
      if ($urandom_range(3) == 0) send_frame(n, 0, 255);
      else begin
        int lo;
        lo = $urandom_range(255);
        send_frame(n, lo, (lo + 40 > 255) ? 255 : lo + 40);
      end
      sent += n;
    end
    wait_drained();
  endtask

  // Receiver holds off so the sender stalls behind a pending result; then sender pauses to drain.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (3000) @(negedge clk);
        hold_off = 1'b0;
      end
      begin
        for (int f = 0; f < 3; f++) send_frame(5, 0, 255);
      end
    join
    wait_drained();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pixel_value = '0;
    in_frame_last = 1'b0;
    out_ready = 1'b0;
    hold_off = 1'b0;
    mismatches = 0;
    cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    foreach (hist[i]) hist[i] = '0;
    pix_count = '0;
    int_sum = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    send_idle_pct = 9;  recv_idle_pct = 48; test_random(155);
    test_backpressure();
    send_idle_pct = 48; recv_idle_pct = 9;  test_random(155);
    send_idle_pct = 0;  recv_idle_pct = 0;  test_random(155);

    repeat (100) @(negedge clk);
    if (mismatches == 0 && thresh_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/core/oht_pkg.sv
rtl/core/oht_ram.sv
rtl/core/oht_mul.sv
rtl/core/oht_dp.sv
rtl/core/oht_ctrl.sv
rtl/core/otsu_histogram_threshold_unit.sv
tb/tb_otsu_histogram_threshold_unit.sv
